/* rtl/core/hta_pkg.sv */
`default_nettype none
package hta_pkg;

    localparam int unsigned COORD_W = 16;
    localparam int unsigned ANGLE_W = 16;
    localparam int unsigned TURN_W  = 32;
    localparam int unsigned DEN_LIM = 40;
    localparam int unsigned MAP_LIM = 30;

    // Arctangent of 2^-i in units of 2^-32 turn.
    localparam logic [TURN_W-1:0] ATAN_TAB [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000
    };

    // One vector in the rotation chain.
    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic [TURN_W-1:0]  ang;
    } t_rot;

    // Halve both parts, truncating toward zero, until both fit in lim bits.
    function automatic void narrow_pair(input logic signed [95:0] a_re,
                                        input logic signed [95:0] a_im,
                                        input int unsigned lim,
                                        output logic signed [95:0] o_re,
                                        output logic signed [95:0] o_im);
        logic [95:0] m_re;
        logic [95:0] m_im;
        logic [95:0] m_or;
        int unsigned sh;
        m_re = a_re[95] ? 96'(-a_re) : 96'(a_re);
        m_im = a_im[95] ? 96'(-a_im) : 96'(a_im);
        m_or = (m_re | m_im) >> lim;
        sh = 0;
        for (int unsigned k = 0; k < 96; k++) begin
            if (m_or[k]) sh = k + 1;
        end
        m_re = m_re >> sh;
        m_im = m_im >> sh;
        o_re = a_re[95] ? -$signed(m_re) : $signed(m_re);
        o_im = a_im[95] ? -$signed(m_im) : $signed(m_im);
    endfunction

endpackage
`default_nettype wire

/* rtl/core/hta_stream_if.sv */
`default_nettype none
interface hta_stream_if #(
    parameter int unsigned WIDTH = 96
);
    logic             valid;
    logic             ready;
    logic [WIDTH-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/hta_map.sv */
`default_nettype none
// Computes the angle-carrying vector w for one vertex over three stages.
module hta_map
    import hta_pkg::*;
#(
    parameter int unsigned FRAC_BITS = 15
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic signed [COORD_W-1:0] i_p_re,
    input  wire logic signed [COORD_W-1:0] i_p_im,
    input  wire logic signed [COORD_W-1:0] i_q_re,
    input  wire logic signed [COORD_W-1:0] i_q_im,
    input  wire logic signed [COORD_W-1:0] i_r_re,
    input  wire logic signed [COORD_W-1:0] i_r_im,
    output t_rot                           o_vec
);
    localparam logic signed [95:0] ONE = 96'sd1 <<< (2 * FRAC_BITS);
    // Narrowed values keep a sign bit above their magnitude limit.
    localparam int unsigned E_W = DEN_LIM + 1;
    localparam int unsigned P_W = MAP_LIM + 1;

    logic signed [E_W-1:0] r_eu_re, r_eu_im, r_ev_re, r_ev_im;
    logic signed [16:0] r_nu_re, r_nu_im, r_nv_re, r_nv_im;
    logic signed [P_W-1:0] r_pu_re, r_pu_im, r_pv_re, r_pv_im;
    logic signed [95:0] n_eu_re, n_eu_im, n_ev_re, n_ev_im;
    logic signed [95:0] n_pu_re, n_pu_im, n_pv_re, n_pv_im;
    logic signed [95:0] t_ure, t_uim, t_vre, t_vim, w_re, w_im, n_w_re, n_w_im;
    logic signed [95:0] e_ure, e_uim, e_vre, e_vim;
    logic signed [95:0] s_ure, s_uim, s_vre, s_vim;
    logic signed [95:0] xp, yp, x1, y1, xq, yq, xr, yr;

    // Stage 1: conjugate denominators and differences.
    always_comb begin
        xp = 96'(i_p_re); yp = 96'(i_p_im);
        xq = 96'(i_q_re); yq = 96'(i_q_im);
        xr = 96'(i_r_re); yr = 96'(i_r_im);
        x1 = xp; y1 = yp;
        narrow_pair(ONE - x1 * xr - y1 * yr, x1 * yr - y1 * xr, DEN_LIM, n_eu_re, n_eu_im);
        narrow_pair(ONE - x1 * xq - y1 * yq, x1 * yq - y1 * xq, DEN_LIM, n_ev_re, n_ev_im);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_eu_re <= E_W'(n_eu_re); r_eu_im <= E_W'(n_eu_im);
            r_ev_re <= E_W'(n_ev_re); r_ev_im <= E_W'(n_ev_im);
            r_nu_re <= 17'(i_r_re) - 17'(i_p_re);
            r_nu_im <= 17'(i_r_im) - 17'(i_p_im);
            r_nv_re <= 17'(i_q_re) - 17'(i_p_re);
            r_nv_im <= 17'(i_q_im) - 17'(i_p_im);
        end
    end

    // Stage 2: difference times conjugate denominator.
    always_comb begin
        t_ure = 96'(r_nu_re); t_uim = 96'(r_nu_im);
        t_vre = 96'(r_nv_re); t_vim = 96'(r_nv_im);
        e_ure = 96'(r_eu_re); e_uim = 96'(r_eu_im);
        e_vre = 96'(r_ev_re); e_vim = 96'(r_ev_im);
        narrow_pair(t_ure * e_ure - t_uim * e_uim, t_ure * e_uim + t_uim * e_ure,
                    MAP_LIM, n_pu_re, n_pu_im);
        narrow_pair(t_vre * e_vre - t_vim * e_vim, t_vre * e_vim + t_vim * e_vre,
                    MAP_LIM, n_pv_re, n_pv_im);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pu_re <= P_W'(n_pu_re); r_pu_im <= P_W'(n_pu_im);
            r_pv_re <= P_W'(n_pv_re); r_pv_im <= P_W'(n_pv_im);
        end
    end

    // Stage 3: v times conj(u), narrowed to the rotation input range.
    always_comb begin
        s_ure = 96'(r_pu_re); s_uim = 96'(r_pu_im);
        s_vre = 96'(r_pv_re); s_vim = 96'(r_pv_im);
        w_re = s_vre * s_ure + s_vim * s_uim;
        w_im = s_vim * s_ure - s_vre * s_uim;
        narrow_pair(w_re, w_im, MAP_LIM, n_w_re, n_w_im);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_vec.x   <= 34'(n_w_re);
            o_vec.y   <= 34'(n_w_im);
            o_vec.ang <= '0;
        end
    end
endmodule
`default_nettype wire

/* rtl/core/hta_cell.sv */
`default_nettype none
// One vectoring rotation step; step index STEP fixes shift and table entry.
module hta_cell
    import hta_pkg::*;
#(
    parameter int unsigned STEP = 0
) (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_rot i_vec,
    output t_rot      o_vec
);
    logic signed [33:0] dx, dy;
    t_rot n_vec;

    // Arithmetic shift is a floor shift on two's complement values.
    always_comb begin
        dx = i_vec.y >>> STEP;
        dy = i_vec.x >>> STEP;
        n_vec = i_vec;
        if (!i_vec.y[33]) begin
            n_vec.x   = i_vec.x + dx;
            n_vec.y   = i_vec.y - dy;
            n_vec.ang = i_vec.ang + ATAN_TAB[STEP];
        end else begin
            n_vec.x   = i_vec.x - dx;
            n_vec.y   = i_vec.y + dy;
            n_vec.ang = i_vec.ang - ATAN_TAB[STEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) o_vec <= n_vec;
    end
endmodule
`default_nettype wire

/* rtl/core/hta_lane.sv */
`default_nettype none
// One vertex: map stages, half-turn fold, chain of rotation cells, rounding.
module hta_lane
    import hta_pkg::*;
#(
    parameter int unsigned FRAC_BITS      = 15,
    parameter int unsigned ROTATION_STEPS = 16
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_en,
    input  wire logic signed [COORD_W-1:0] i_p_re,
    input  wire logic signed [COORD_W-1:0] i_p_im,
    input  wire logic signed [COORD_W-1:0] i_q_re,
    input  wire logic signed [COORD_W-1:0] i_q_im,
    input  wire logic signed [COORD_W-1:0] i_r_re,
    input  wire logic signed [COORD_W-1:0] i_r_im,
    output logic [ANGLE_W-1:0]             o_angle
);
    t_rot w_vec, r_fold;
    t_rot chain [ROTATION_STEPS+1];
    logic r_zero [ROTATION_STEPS+1];
    logic [TURN_W-1:0] rnd;

    hta_map #(.FRAC_BITS(FRAC_BITS)) u_map (
        .i_clk, .i_en, .i_p_re, .i_p_im, .i_q_re, .i_q_im, .i_r_re, .i_r_im,
        .o_vec(w_vec)
    );

    // Fold the left half plane by adding half a turn.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (w_vec.x == '0) && (w_vec.y == '0);
            if (w_vec.x[33]) begin
                r_fold.x   <= -w_vec.x;
                r_fold.y   <= -w_vec.y;
                r_fold.ang <= 32'h80000000;
            end else begin
                r_fold <= w_vec;
            end
        end
    end
    assign chain[0] = r_fold;

    for (genvar g = 0; g < ROTATION_STEPS; g++) begin : g_cell
        hta_cell #(.STEP(g)) u_cell (
            .i_clk, .i_en, .i_vec(chain[g]), .o_vec(chain[g+1])
        );
        always_ff @(posedge i_clk) begin
            if (i_en) r_zero[g+1] <= r_zero[g];
        end
    end

    // Round to nearest, half up; zero vector gives angle zero.
    assign rnd = chain[ROTATION_STEPS].ang + 32'h00008000;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_angle <= r_zero[ROTATION_STEPS] ? '0 : rnd[TURN_W-1 -: ANGLE_W];
        end
    end
endmodule
`default_nettype wire

/* rtl/core/hyperbolic_triangle_angles.sv */
`default_nettype none
// Channel | Dir | Payload
// in      | in  | first/second/third re,im, 6 x s16
// out     | out | angle_first/second/third, 3 x u16
//
// One request accepted per cycle unless the output stalls; latency is set
// by three map stages, one fold stage, one cell per rotation step and
// one rounding stage. Synchronous active-low reset clears valid bits only.
// A stalled output freezes the whole pipeline; input ready then drops.
module hyperbolic_triangle_angles
    import hta_pkg::*;
#(
    parameter int unsigned FRAC_BITS      = 15,
    parameter int unsigned ROTATION_STEPS = 16
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    hta_stream_if.sink   i_in,
    hta_stream_if.source o_out
);
    localparam int unsigned LAT = ROTATION_STEPS + 5;

    logic [LAT-1:0] r_vld;
    logic en;
    logic signed [COORD_W-1:0] c [6];

    // Pipeline advances unless a finished result is held back.
    assign en = !r_vld[LAT-1] || o_out.ready;
    assign i_in.ready = en;
    assign o_out.valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_in.valid};
        end
    end

    for (genvar k = 0; k < 6; k++) begin : g_unpack
        assign c[k] = i_in.data[k*COORD_W +: COORD_W];
    end

    hta_lane #(.FRAC_BITS(FRAC_BITS), .ROTATION_STEPS(ROTATION_STEPS)) u_first (
        .i_clk, .i_en(en), .i_p_re(c[0]), .i_p_im(c[1]), .i_q_re(c[2]), .i_q_im(c[3]),
        .i_r_re(c[4]), .i_r_im(c[5]), .o_angle(o_out.data[15:0])
    );
    hta_lane #(.FRAC_BITS(FRAC_BITS), .ROTATION_STEPS(ROTATION_STEPS)) u_second (
        .i_clk, .i_en(en), .i_p_re(c[2]), .i_p_im(c[3]), .i_q_re(c[4]), .i_q_im(c[5]),
        .i_r_re(c[0]), .i_r_im(c[1]), .o_angle(o_out.data[31:16])
    );
    hta_lane #(.FRAC_BITS(FRAC_BITS), .ROTATION_STEPS(ROTATION_STEPS)) u_third (
        .i_clk, .i_en(en), .i_p_re(c[4]), .i_p_im(c[5]), .i_q_re(c[0]), .i_q_im(c[1]),
        .i_r_re(c[2]), .i_r_im(c[3]), .o_angle(o_out.data[47:32])
    );

    // A waiting result blocks new requests.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !i_in.ready) else $error("stall leak");
    // Valid output persists while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |=> o_out.valid) else $error("lost result");
    // Reset empties the pipeline.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("valid after reset");
endmodule
`default_nettype wire
